[rtl/sha1_pkg.sv]
`default_nettype none
package sha1_pkg;
	localparam logic [1:0] ACT_ABSORB   = 2'd0;
	localparam logic [1:0] ACT_FINALIZE = 2'd1;
	localparam logic [1:0] ACT_RESTART  = 2'd2;

	localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
		32'h10325476, 32'hc3d2e1f0};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} rnd_ctl_t;

	function automatic word_t round_k(input logic [6:0] r);
		word_t k;
		if (r < 7'd20) begin
			k = 32'h5A827999;
		end else if (r < 7'd40) begin
			k = 32'h6ED9EBA1;
		end else if (r < 7'd60) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

	function automatic word_t round_f(input logic [6:0] r, input word_t b, input word_t c,
		input word_t d);
		word_t f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r < 7'd40) begin
			f = b ^ c ^ d;
		end else if (r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction
endpackage
`default_nettype wire

[rtl/sha1_round.sv]
`default_nettype none
module sha1_round (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire sha1_pkg::word_t    hin [5],
	input  wire sha1_pkg::word_t    win,
	output sha1_pkg::word_t         hout [5],
	output logic [3:0]              widx,
	output sha1_pkg::rnd_ctl_t      ctl
);
	logic [6:0]       r_q;
	logic             busy_q;
	logic             done_q;
	sha1_pkg::word_t  v_q [5];
	sha1_pkg::word_t  w_q [16];
	sha1_pkg::word_t  w;
	sha1_pkg::word_t  wx;
	sha1_pkg::word_t  t;
	logic [3:0]       i0;

	assign i0 = r_q[3:0];
	assign widx = i0;
	assign wx = w_q[i0 - 4'd3] ^ w_q[i0 - 4'd8] ^ w_q[i0 - 4'd14] ^ w_q[i0];
	assign w = (r_q < 7'd16) ? win : {wx[30:0], wx[31]};
	assign t = {v_q[0][26:0], v_q[0][31:27]} + sha1_pkg::round_f(r_q, v_q[1], v_q[2], v_q[3])
		+ v_q[4] + w + sha1_pkg::round_k(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			r_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				r_q <= '0;
			end else if (busy_q) begin
				if (r_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				r_q <= r_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 5; i++) v_q[i] <= hin[i];
		end else if (busy_q) begin
			w_q[i0] <= w;
			v_q[0] <= t;
			v_q[1] <= v_q[0];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
	end

	always_comb begin
		for (int i = 0; i < 5; i++) hout[i] = hin[i] + v_q[i];
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule
`default_nettype wire

[rtl/sha1_hash_engine_core.sv]
`default_nettype none
// channel | dir | handshake        | payload
// in      | in  | in_valid/in_stall  | action, data_byte
// out     | out | out_valid/out_stall| digest_word, word_index, last_word
// Absorb stores one byte; every 64th byte then stalls the input for a block pass:
// a start of the shared round unit, 80 rounds, and a fold. Finalize runs one or two
// block passes, then five result requests. Reset loads the initial chain and zero
// count. in_stall is high while any pass or output runs.
module sha1_hash_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ABS  = 3'd1;
	localparam logic [2:0] ST_PAD1 = 3'd2;
	localparam logic [2:0] ST_PAD2 = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       st_q;
	logic [60:0]      cnt_q;
	logic [31:0]      buf_q [16];
	logic [31:0]      bw;
	sha1_pkg::word_t  ch_q [5];
	sha1_pkg::word_t  fh_q [5];
	logic             start;
	sha1_pkg::word_t  hin [5];
	sha1_pkg::word_t  hout [5];
	sha1_pkg::word_t  win;
	logic [3:0]       widx;
	sha1_pkg::rnd_ctl_t ctl;
	logic [5:0]       pos_q;
	logic [63:0]      bits_q;
	logic             two_q;
	logic             pass2_q;
	logic [2:0]       oi_q;
	logic             acc;
	logic [7:0]       pb [4];

	assign in_stall = (st_q != ST_IDLE) || ctl.busy || start;
	assign acc = in_valid && !in_stall;
	assign bw = buf_q[widx];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			logic [5:0] p;
			logic [7:0] mb;
			p = {widx, 2'(j)};
			mb = bw[31 - 8 * j -: 8];
			if (st_q == ST_ABS) begin
				pb[j] = mb;
			end else if (!pass2_q && two_q) begin
				pb[j] = (p < pos_q) ? mb : (p == pos_q) ? sha1_pkg::PAD_BYTE : 8'd0;
			end else if (p >= 6'd56) begin
				pb[j] = bits_q[6'(63 - 8 * (p - 6'd56)) -: 8];
			end else if (two_q) begin
				pb[j] = 8'd0;
			end else begin
				pb[j] = (p < pos_q) ? mb : (p == pos_q) ? sha1_pkg::PAD_BYTE : 8'd0;
			end
		end
	end
	assign win = {pb[0], pb[1], pb[2], pb[3]};

	always_comb begin
		for (int i = 0; i < 5; i++) hin[i] = (st_q == ST_ABS) ? ch_q[i] : fh_q[i];
	end

	sha1_round u_round (
		.clk(clk), .arst_n(arst_n), .start(start), .hin(hin), .win(win),
		.hout(hout), .widx(widx), .ctl(ctl)
	);

	always_ff @(posedge clk) begin
		if (acc && action == sha1_pkg::ACT_ABSORB)
			buf_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			start <= 1'b0;
			oi_q <= '0;
			pass2_q <= 1'b0;
			pos_q <= '0;
			bits_q <= '0;
			two_q <= 1'b0;
			for (int i = 0; i < 5; i++) ch_q[i] <= sha1_pkg::H_INIT[i];
			for (int i = 0; i < 5; i++) fh_q[i] <= sha1_pkg::H_INIT[i];
		end else begin
			start <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						case (action)
							sha1_pkg::ACT_ABSORB: begin
								cnt_q <= cnt_q + 61'd1;
								if (cnt_q[5:0] == 6'd63) begin
									st_q <= ST_ABS;
									start <= 1'b1;
								end
							end
							sha1_pkg::ACT_FINALIZE: begin
								pos_q <= cnt_q[5:0];
								bits_q <= {cnt_q, 3'd0};
								two_q <= cnt_q[5:0] >= 6'd56;
								pass2_q <= 1'b0;
								for (int i = 0; i < 5; i++) fh_q[i] <= ch_q[i];
								st_q <= ST_PAD1;
								start <= 1'b1;
							end
							sha1_pkg::ACT_RESTART: begin
								cnt_q <= '0;
								for (int i = 0; i < 5; i++) ch_q[i] <= sha1_pkg::H_INIT[i];
							end
							default: begin
							end
						endcase
					end
				end
				ST_ABS: begin
					if (ctl.done) begin
						for (int i = 0; i < 5; i++) ch_q[i] <= hout[i];
						st_q <= ST_IDLE;
					end
				end
				ST_PAD1: begin
					if (ctl.done) begin
						for (int i = 0; i < 5; i++) fh_q[i] <= hout[i];
						if (two_q) begin
							pass2_q <= 1'b1;
							start <= 1'b1;
							st_q <= ST_PAD2;
						end else begin
							oi_q <= '0;
							st_q <= ST_OUT;
						end
					end
				end
				ST_PAD2: begin
					if (ctl.done) begin
						for (int i = 0; i < 5; i++) fh_q[i] <= hout[i];
						oi_q <= '0;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						oi_q <= oi_q + 3'd1;
						if (oi_q == 3'd4) st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = (st_q == ST_OUT);
	assign digest_word = fh_q[oi_q];
	assign word_index = oi_q;
	assign last_word = (oi_q == 3'd4);
endmodule
`default_nettype wire
